FILE: rtl/core/rd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd_pkg
// Shared widths and the per-stage data type of the restoring divider.
// ----------------------------------------------------------------------------
package rd_pkg;

    localparam int WIDTH = 32;

    typedef logic [WIDTH-1:0] t_word;

    // rem: partial remainder; nq: unused dividend bits on top, quotient bits below
    typedef struct packed {
        t_word rem;
        t_word nq;
        t_word den;
    } t_stage;

endpackage

FILE: rtl/core/rd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd_req_if
// Request channel of the divider: dividend and divisor with valid/ready.
// ----------------------------------------------------------------------------
interface rd_req_if
    import rd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word dividend;
    t_word divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

FILE: rtl/core/rd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd_rsp_if
// Response channel of the divider: quotient and remainder with valid/ready.
// ----------------------------------------------------------------------------
interface rd_rsp_if
    import rd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word quotient;
    t_word remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

FILE: rtl/core/restoring_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restoring_divider
// Unsigned WIDTH-bit restoring divider built as a chain of WIDTH step cells.
// Requests pass the WIDTH registered cells in order. Throughput: one division
// per cycle unless o_rsp stalls; each cell stage advances independently,
// so bubbles collapse and a stalled response blocks only the stages behind it.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
// ----------------------------------------------------------------------------
module restoring_divider
    import rd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    rd_req_if.sink   i_req,
    rd_rsp_if.source o_rsp
);

    logic   w_valid [WIDTH+1];
    logic   w_ready [WIDTH+1];
    t_stage w_data  [WIDTH+1];

    assign w_valid[0]      = i_req.valid;
    assign i_req.ready     = w_ready[0];
    assign w_data[0].rem   = '0;
    assign w_data[0].nq    = i_req.dividend;
    assign w_data[0].den   = i_req.divisor;

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        rd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev_valid (w_valid[g]),
            .o_prev_ready (w_ready[g]),
            .i_prev       (w_data[g]),
            .o_next_valid (w_valid[g+1]),
            .i_next_ready (w_ready[g+1]),
            .o_next       (w_data[g+1])
        );
    end

    assign w_ready[WIDTH]  = o_rsp.ready;
    assign o_rsp.valid     = w_valid[WIDTH];
    assign o_rsp.quotient  = w_data[WIDTH].nq;
    assign o_rsp.remainder = w_data[WIDTH].rem;

endmodule

FILE: rtl/core/rd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd_cell
// One restoring step: shift in a dividend bit, trial-subtract the divisor,
// keep or restore, and register the result for the next cell.
// ----------------------------------------------------------------------------
module rd_cell
    import rd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_prev_valid,
    output logic   o_prev_ready,
    input  t_stage i_prev,
    output logic   o_next_valid,
    input  logic   i_next_ready,
    output t_stage o_next
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    logic          w_top;
    t_word         w_trial;
    logic [WIDTH:0] w_diff;
    logic          w_sub;

    always_comb begin
        w_top   = i_prev.rem[WIDTH-1];
        w_trial = {i_prev.rem[WIDTH-2:0], i_prev.nq[WIDTH-1]};
        w_diff  = {w_top, w_trial} - {1'b0, i_prev.den};
        w_sub   = w_top | ~w_diff[WIDTH];
        n_data.rem = w_sub ? w_diff[WIDTH-1:0] : w_trial;
        n_data.nq  = {i_prev.nq[WIDTH-2:0], w_sub};
        n_data.den = i_prev.den;
    end

    assign o_prev_ready = ~r_valid | i_next_ready;
    assign o_next_valid = r_valid;
    assign o_next       = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_prev_ready) begin
            r_valid <= i_prev_valid;
        end
    end

    // hold payload unless a new transaction enters
    always_ff @(posedge i_clk) begin
        if (o_prev_ready && i_prev_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unsigned restoring divider. A driver feeds
// dividend/divisor transactions from a queue; a monitor computes the expected
// quotient and remainder of every accepted request and compares responses in
// order. Both channels idle at random, outside one stretch free of random idles.
// ----------------------------------------------------------------------------
module tb;
    import rd_pkg::*;

    localparam int N_RANDOM    = 1700;
    localparam int CALM_LO     = 700;
    localparam int CALM_HI     = 1000;
    localparam int IDLE_PCT    = 7;
    localparam int DRAIN_WAIT  = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_word dividend;
        t_word divisor;
        logic  drain;
    } t_div_req;

    typedef struct packed {
        t_word quotient;
        t_word remainder;
    } t_div_res;

    logic i_clk;
    logic i_rst_n;

    rd_req_if req_if ();
    rd_rsp_if rsp_if ();

    restoring_divider dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_div_req div_pending_q[$];
    t_div_res qr_expected_q[$];
    int       n_total;
    int       n_accepted;
    int       n_errors;
    bit       req_taken;

    function automatic t_div_res restore_divide(t_word num, t_word den);
        logic [WIDTH:0] part;
        t_div_res       res;
        part = '0;
        res.quotient = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            part = {part[WIDTH-1:0], num[i]};
            res.quotient = res.quotient << 1;
            if (part >= {1'b0, den}) begin
                part = part - {1'b0, den};
                res.quotient[0] = 1'b1;
            end
        end
        res.remainder = part[WIDTH-1:0];
        return res;
    endfunction

    function automatic bit calm_window();
        return n_accepted >= CALM_LO && n_accepted < CALM_HI;
    endfunction

    task automatic note_error(string what, t_word exp_val, t_word got_val);
        if (n_errors < MAX_REPORTS) begin
            $display("mismatch %s: expected %h got %h at %0t", what, exp_val, got_val, $time);
        end
        n_errors++;
    endtask

    task automatic push_div(t_word num, t_word den, logic drain);
        t_div_req r;
        r.dividend = num;
        r.divisor  = den;
        r.drain    = drain;
        div_pending_q.push_back(r);
        n_total++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.dividend = '0;
        req_if.divisor  = '0;
        rsp_if.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: request channel
    always @(negedge i_clk) begin
        t_div_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (div_pending_q.size() == 0
                    || (div_pending_q[0].drain && qr_expected_q.size() != 0)
                    || (!calm_window() && $urandom_range(0, 99) < IDLE_PCT)) begin
                req_if.valid <= 1'b0;
            end else begin
                nxt = div_pending_q.pop_front();
                req_if.valid    <= 1'b1;
                req_if.dividend <= nxt.dividend;
                req_if.divisor  <= nxt.divisor;
            end
        end
    end

    // driver: response back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= calm_window() || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_div_res got;
        t_div_res want;
        req_taken = i_rst_n && req_if.valid && req_if.ready;
        if (req_taken) begin
            qr_expected_q.push_back(restore_divide(req_if.dividend, req_if.divisor));
            n_accepted++;
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.quotient  = rsp_if.quotient;
            got.remainder = rsp_if.remainder;
            if (qr_expected_q.size() == 0) begin
                note_error("unexpected quotient", '0, got.quotient);
            end else begin
                want = qr_expected_q.pop_front();
                if (got.quotient !== want.quotient) begin
                    note_error("quotient", want.quotient, got.quotient);
                end
                if (got.remainder !== want.remainder) begin
                    note_error("remainder", want.remainder, got.remainder);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_word num;
        t_word den;
        int    kind;
        n_total    = 0;
        n_accepted = 0;
        n_errors   = 0;
        req_taken  = 1'b0;

        push_div('0, '0, 1'b0);
        push_div('1, '0, 1'b0);
        push_div(32'h1234_5678, '0, 1'b0);
        push_div('0, '1, 1'b0);
        push_div('1, '1, 1'b0);
        push_div('1, 32'd1, 1'b0);
        push_div(32'd1, '1, 1'b0);
        push_div(32'd1, 32'd1, 1'b0);
        push_div('1, 32'hFFFF_FFFE, 1'b0);
        push_div('1, 32'h8000_0001, 1'b0);
        push_div(32'h8000_0000, 32'h8000_0000, 1'b0);
        push_div(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_div(32'hC000_0000, 32'h8000_0001, 1'b0);
        push_div(32'h8000_0000, 32'd3, 1'b0);
        push_div(32'd12345, 32'd7, 1'b0);
        push_div(32'd7, 32'd12345, 1'b0);
        push_div(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        push_div(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        push_div('1, 32'd2, 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            num  = $urandom;
            kind = $urandom_range(0, 9);
            case (kind)
                0: den = '0;
                1: den = $urandom_range(1, 255);
                2: den = num - $urandom_range(0, 3);
                3: den = $urandom | 32'h8000_0000;
                4: den = $urandom >> $urandom_range(0, 31);
                5: begin
                    num = num >> $urandom_range(0, 31);
                    den = $urandom >> $urandom_range(0, 31);
                end
                default: den = $urandom;
            endcase
            push_div(num, den, n == 0 || n == 900 || n == 1400);
        end

        while (n_accepted < n_total || qr_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0 && qr_expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/rd_pkg.sv
rtl/core/rd_req_if.sv
rtl/core/rd_rsp_if.sv
rtl/core/rd_cell.sv
rtl/core/restoring_divider.sv
tb/tb.sv
